>>> src/plsr_pkg.sv
// shared types, codes and sizes for the positional sparse row list
`timescale 1ns / 1ps

package plsr_pkg;

    localparam int REQ_BITS       = 2;
    localparam int IN_VALUE_BITS  = 32;
    localparam int COL_BITS       = 16;
    localparam int POS_BITS       = 7;
    localparam int LEN_BITS       = 7;
    localparam int STATUS_BITS    = 2;

    localparam int CAPACITY_DEF   = 64;
    localparam int VALUE_BITS_DEF = 32;

    localparam logic [REQ_BITS-1:0] REQ_APPEND = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_INSERT = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_DELETE = 2'd2;
    localparam logic [REQ_BITS-1:0] REQ_READ   = 2'd3;

    localparam logic [STATUS_BITS-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [REQ_BITS-1:0]             req_type;
        logic signed [IN_VALUE_BITS-1:0] entry_value;
        logic [COL_BITS-1:0]             entry_column;
        logic [POS_BITS-1:0]             position;
    } req_t;

    typedef struct packed {
        logic signed [IN_VALUE_BITS-1:0] read_value;
        logic [COL_BITS-1:0]             read_column;
        logic [LEN_BITS-1:0]             length;
        logic [STATUS_BITS-1:0]          status;
    } rsp_t;

    typedef struct packed {
        logic append;
        logic insert;
        logic delete;
        logic read;
    } cmd_t;

endpackage

>>> src/plsr_cell.sv
// one storage entry with its shift and write selection
`timescale 1ns / 1ps

module plsr_cell #(
    parameter int VALUE_BITS = plsr_pkg::VALUE_BITS_DEF
) (
    input  logic                          aclk,
    input  plsr_pkg::cmd_t                cmd,
    input  logic                          at_idx,
    input  logic                          past_idx,
    input  logic                          at_cnt,
    input  logic [VALUE_BITS-1:0]         new_value,
    input  logic [plsr_pkg::COL_BITS-1:0] new_column,
    input  logic [VALUE_BITS-1:0]         below_value,
    input  logic [plsr_pkg::COL_BITS-1:0] below_column,
    input  logic [VALUE_BITS-1:0]         above_value,
    input  logic [plsr_pkg::COL_BITS-1:0] above_column,
    output logic [VALUE_BITS-1:0]         value,
    output logic [plsr_pkg::COL_BITS-1:0] column
);
    import plsr_pkg::*;

    logic [VALUE_BITS-1:0] value_reg;
    logic [VALUE_BITS-1:0] value_next;
    logic [COL_BITS-1:0]   column_reg;
    logic [COL_BITS-1:0]   column_next;

    always_comb begin
        priority if ((cmd.append && at_cnt) || (cmd.insert && at_idx)) begin
            value_next  = new_value;
            column_next = new_column;
        end else if (cmd.insert && past_idx) begin
            value_next  = below_value;
            column_next = below_column;
        end else if (cmd.delete && (at_idx || past_idx)) begin
            value_next  = above_value;
            column_next = above_column;
        end else begin
            value_next  = value_reg;
            column_next = column_reg;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg  <= value_next;
        column_reg <= column_next;
    end

    assign value  = value_reg;
    assign column = column_reg;

endmodule

>>> src/plsr_decode.sv
// request decode: range and full checks, status and next entry count
`timescale 1ns / 1ps

module plsr_decode #(
    parameter int CAPACITY = plsr_pkg::CAPACITY_DEF
) (
    input  plsr_pkg::req_t                      req,
    input  logic                                fire,
    input  logic [$clog2(CAPACITY+1)-1:0]       count,
    output plsr_pkg::cmd_t                      cmd,
    output logic [plsr_pkg::STATUS_BITS-1:0]    status,
    output logic [$clog2(CAPACITY+1)-1:0]       count_next
);
    import plsr_pkg::*;

    localparam int CNT_BITS = $clog2(CAPACITY + 1);
    localparam int CW       = (CNT_BITS > POS_BITS) ? CNT_BITS : POS_BITS;

    logic [CW-1:0] count_w;
    logic [CW-1:0] pos_w;
    logic          full;
    logic          pos_ok;
    cmd_t          ok;

    assign count_w = CW'(count);
    assign pos_w   = CW'(req.position);
    assign full    = count_w >= CW'(CAPACITY);
    assign pos_ok  = (req.position != '0) && (pos_w <= count_w);

    always_comb begin
        ok     = '0;
        status = ST_DONE;
        unique case (req.req_type)
            REQ_APPEND: begin
                if (full) status = ST_FULL;
                else      ok.append = 1'b1;
            end
            REQ_INSERT: begin
                if (!pos_ok)   status = ST_RANGE;
                else if (full) status = ST_FULL;
                else           ok.insert = 1'b1;
            end
            REQ_DELETE: begin
                if (!pos_ok) status = ST_RANGE;
                else         ok.delete = 1'b1;
            end
            REQ_READ: begin
                if (!pos_ok) status = ST_RANGE;
                else         ok.read = 1'b1;
            end
            default: status = ST_DONE;
        endcase
    end

    always_comb begin
        cmd = fire ? ok : '0;
        if (ok.append || ok.insert) begin
            count_next = count + CNT_BITS'(1);
        end else if (ok.delete) begin
            count_next = count - CNT_BITS'(1);
        end else begin
            count_next = count;
        end
    end

endmodule

>>> src/positional_sparse_row_list_unit.sv
// top level of the positional sparse row list: request/result registers and entry row
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY (value, column) entries, one row of a sparse
// matrix. Each request appends, inserts before a 1-based position, deletes at a
// position or reads at a position, and gives exactly one result with the read
// entry, the length afterwards and a status (done, position out of range, list
// full). A request is registered on entry and its result in an output
// register; every entry has its own register with a neighbor select, so insert
// and delete shift the whole row together. One request is taken every clock
// cycle while results are taken. Entries beyond the length hold no
// defined data.
module positional_sparse_row_list_unit #(
    parameter int CAPACITY   = plsr_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = plsr_pkg::VALUE_BITS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  plsr_pkg::req_t s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output plsr_pkg::rsp_t m_data
);
    import plsr_pkg::*;

    localparam int CNT_BITS = $clog2(CAPACITY + 1);
    localparam int CW       = (CNT_BITS > POS_BITS) ? CNT_BITS : POS_BITS;

    logic                  in_valid_reg;
    req_t                  in_reg;
    logic                  out_valid_reg;
    rsp_t                  out_reg;
    rsp_t                  out_next;
    logic [CNT_BITS-1:0]   count_reg;
    logic [CNT_BITS-1:0]   count_next;
    logic                  advance;
    cmd_t                  cmd;
    logic [STATUS_BITS-1:0] status;

    logic [CW-1:0]         count_w;
    logic [CW-1:0]         idx_w;
    logic [CW-1:0]         len_w;
    logic [VALUE_BITS-1:0] new_value;
    logic [VALUE_BITS-1:0] cell_value  [CAPACITY];
    logic [COL_BITS-1:0]   cell_column [CAPACITY];
    logic [CAPACITY-1:0]   at_idx;
    logic [CAPACITY-1:0]   past_idx;
    logic [CAPACITY-1:0]   at_cnt;
    logic [VALUE_BITS-1:0] sel_value;
    logic [COL_BITS-1:0]   sel_column;
    logic [IN_VALUE_BITS-1:0] rd_value;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    plsr_decode #(
        .CAPACITY (CAPACITY)
    ) u_decode (
        .req        (in_reg),
        .fire       (advance),
        .count      (count_reg),
        .cmd        (cmd),
        .status     (status),
        .count_next (count_next)
    );

    assign count_w = CW'(count_reg);
    assign idx_w   = CW'(in_reg.position) - CW'(1);

    generate
        if (VALUE_BITS <= IN_VALUE_BITS) begin : g_val_narrow
            assign new_value = in_reg.entry_value[VALUE_BITS-1:0];
        end else begin : g_val_wide
            assign new_value = {{(VALUE_BITS-IN_VALUE_BITS){in_reg.entry_value[IN_VALUE_BITS-1]}},
                                in_reg.entry_value};
        end

        if (VALUE_BITS >= IN_VALUE_BITS) begin : g_rd_trunc
            assign rd_value = sel_value[IN_VALUE_BITS-1:0];
        end else begin : g_rd_ext
            assign rd_value = {{(IN_VALUE_BITS-VALUE_BITS){sel_value[VALUE_BITS-1]}}, sel_value};
        end
    endgenerate

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        localparam int BELOW = (i == 0) ? 0 : i - 1;
        localparam int ABOVE = (i == CAPACITY - 1) ? i : i + 1;

        assign at_idx[i]   = idx_w == CW'(i);
        assign past_idx[i] = CW'(i) > idx_w;
        assign at_cnt[i]   = count_w == CW'(i);

        plsr_cell #(
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .aclk         (aclk),
            .cmd          (cmd),
            .at_idx       (at_idx[i]),
            .past_idx     (past_idx[i]),
            .at_cnt       (at_cnt[i]),
            .new_value    (new_value),
            .new_column   (in_reg.entry_column),
            .below_value  (cell_value[BELOW]),
            .below_column (cell_column[BELOW]),
            .above_value  (cell_value[ABOVE]),
            .above_column (cell_column[ABOVE]),
            .value        (cell_value[i]),
            .column       (cell_column[i])
        );
    end

    // one-hot and-or read select
    always_comb begin
        sel_value  = '0;
        sel_column = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            sel_value  = sel_value  | (cell_value[i]  & {VALUE_BITS{at_idx[i]}});
            sel_column = sel_column | (cell_column[i] & {COL_BITS{at_idx[i]}});
        end
    end

    assign len_w = CW'(count_next);

    always_comb begin
        out_next             = '0;
        out_next.length      = len_w[LEN_BITS-1:0];
        out_next.status      = status;
        if (cmd.read) begin
            out_next.read_value  = rd_value;
            out_next.read_column = sel_column;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                count_reg     <= count_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

endmodule
